// ===== hdl/xcfr_pkg.sv =====
package xcfr_pkg;

   localparam int FRAME_OVERHEAD = 4;
   localparam int HEADER_BYTES   = 2;

   localparam logic CSR_START_MARKER = 1'b0;
   localparam logic CSR_END_MARKER   = 1'b1;

   localparam logic [7:0] START_MARKER_RESET = 8'd170;
   localparam logic [7:0] END_MARKER_RESET   = 8'd85;

   typedef enum logic [1:0] {
      ST_WAIT,
      ST_FRAME,
      ST_READ,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      POS_TYPE,
      POS_LEN,
      POS_PAYLOAD,
      POS_CHECK,
      POS_END
   } pos_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_XOR_ERR,
      STAT_END_ERR,
      STAT_LEN_ERR
   } result_status_type;

   typedef struct packed {
      logic              frame_start;
      logic              byte_take;
      logic              rsp_load_err;
      result_status_type err_status;
      logic              rd_issue;
      logic              rsp_load_data;
   } dp_cmd_type;

   typedef struct packed {
      logic    is_start;
      pos_type pos;
      logic    len_big;
      logic    end_ok;
      logic    xor_ok;
      logic    len_zero;
      logic    ptr_last;
      logic    out_free;
   } dp_status_type;

endpackage

// ===== hdl/xor_checked_frame_receiver_unit.sv =====
// A single-result outcome (error, empty frame) sits in the output register the cycle after
// the deciding byte is taken (the end byte, or the length byte when the length is too big).
// One byte per cycle while receiving and the output register is free; a good frame
// then drains its payload (payload store read, output load when free), taking no bytes.
// Reset: synchronous, active high; markers return to 0xAA / 0x55, store is not cleared.
module xor_checked_frame_receiver_unit import xcfr_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_packet_type,
   output logic       rsp_has_data,
   output logic [7:0] rsp_payload_byte,
   output logic [4:0] rsp_byte_index,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   xcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   xcfr_dp #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_has_data     (rsp_has_data),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last)
   );

   a_no_take_while_draining: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_issue || cmd.rsp_load_data) |-> !req_ready)
      else $error("input taken while payload drains");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rsp_load_err && cmd.rsp_load_data))
      else $error("two output loads in one cycle");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load_err || cmd.rsp_load_data) |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten before transfer");

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> (cmd.rsp_load_data || (rsp_valid && !rsp_ready)))
      else $error("store read not followed by output load");

endmodule

// ===== hdl/xcfr_ctrl.sv =====
module xcfr_ctrl import xcfr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.err_status = STAT_OK;
      req_ready      = 1'b0;
      req_fire       = 1'b0;
      case (state_ff)
         ST_WAIT: begin
            req_ready = sts.out_free;
            req_fire  = req_valid && sts.out_free;
            if (req_fire && sts.is_start) begin
               cmd.frame_start = 1'b1;
               state_in        = ST_FRAME;
            end
         end
         ST_FRAME: begin
            req_ready = sts.out_free;
            req_fire  = req_valid && sts.out_free;
            if (req_fire) begin
               cmd.byte_take = 1'b1;
               case (sts.pos)
                  POS_LEN: begin
                     if (sts.len_big) begin
                        cmd.rsp_load_err = 1'b1;
                        cmd.err_status   = STAT_LEN_ERR;
                        state_in         = ST_WAIT;
                     end
                  end
                  POS_END: begin
                     state_in = ST_WAIT;
                     if (!sts.end_ok) begin
                        cmd.rsp_load_err = 1'b1;
                        cmd.err_status   = STAT_END_ERR;
                     end else if (!sts.xor_ok) begin
                        cmd.rsp_load_err = 1'b1;
                        cmd.err_status   = STAT_XOR_ERR;
                     end else if (sts.len_zero) begin
                        cmd.rsp_load_err = 1'b1;
                        cmd.err_status   = STAT_OK;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.rsp_load_data = 1'b1;
               state_in          = sts.ptr_last ? ST_WAIT : ST_READ;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

endmodule

// ===== hdl/xcfr_dp.sv =====
module xcfr_dp import xcfr_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_rx_byte,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [7:0]    csr_wr_data,
   input  dp_cmd_type    cmd,
   output dp_status_type sts,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_packet_type,
   output logic          rsp_has_data,
   output logic [7:0]    rsp_payload_byte,
   output logic [4:0]    rsp_byte_index,
   output logic          rsp_last
);

   localparam int CAP = FRAME_BUFFER_BYTES - FRAME_OVERHEAD;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW  = $clog2(CAP + 5);

   logic [7:0]        start_marker_ff, start_marker_in;
   logic [7:0]        end_marker_ff, end_marker_in;
   logic [CW-1:0]     byte_count_ff, byte_count_in;
   logic [7:0]        declared_length_ff, declared_length_in;
   logic [7:0]        running_xor_ff, running_xor_in;
   logic [7:0]        frame_type_ff, frame_type_in;
   logic [7:0]        received_check_ff, received_check_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [7:0]        rd_data_ff;
   logic [7:0]        payload_store_mem [CAP];

   logic              rsp_valid_ff, rsp_valid_in;
   result_status_type rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_type_ff, rsp_type_in;
   logic              rsp_has_ff, rsp_has_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [4:0]        rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [9:0]        count_w, check_pos;
   logic [CW-1:0]     wr_off;
   logic [AW-1:0]     wr_addr;
   logic              store_we;
   logic [AW+4:0]     ptr_ext;
   pos_type           pos;

   always_comb begin
      count_w   = 10'(byte_count_ff);
      check_pos = 10'(declared_length_ff) + 10'(HEADER_BYTES);
      if (byte_count_ff == CW'(0)) begin
         pos = POS_TYPE;
      end else if (byte_count_ff == CW'(1)) begin
         pos = POS_LEN;
      end else if (count_w < check_pos) begin
         pos = POS_PAYLOAD;
      end else if (count_w == check_pos) begin
         pos = POS_CHECK;
      end else begin
         pos = POS_END;
      end
   end

   assign wr_off   = byte_count_ff - CW'(HEADER_BYTES);
   assign wr_addr  = wr_off[AW-1:0];
   assign store_we = cmd.byte_take && (pos == POS_PAYLOAD);
   assign ptr_ext  = {5'b0, rd_ptr_ff};

   assign sts.is_start = (req_rx_byte == start_marker_ff);
   assign sts.pos      = pos;
   assign sts.len_big  = {1'b0, req_rx_byte} > 9'(CAP);
   assign sts.end_ok   = (req_rx_byte == end_marker_ff);
   assign sts.xor_ok   = (running_xor_ff == received_check_ff);
   assign sts.len_zero = (declared_length_ff == 8'd0);
   assign sts.ptr_last = (9'(rd_ptr_ff) + 9'd1) == 9'(declared_length_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      start_marker_in    = start_marker_ff;
      end_marker_in      = end_marker_ff;
      byte_count_in      = byte_count_ff;
      declared_length_in = declared_length_ff;
      running_xor_in     = running_xor_ff;
      frame_type_in      = frame_type_ff;
      received_check_in  = received_check_ff;
      rd_ptr_in          = rd_ptr_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wr_data;
            CSR_END_MARKER:   end_marker_in   = csr_wr_data;
            default: begin
            end
         endcase
      end

      if (cmd.frame_start) begin
         byte_count_in = '0;
         rd_ptr_in     = '0;
      end

      if (cmd.byte_take) begin
         byte_count_in = byte_count_ff + CW'(1);
         case (pos)
            POS_TYPE: begin
               frame_type_in  = req_rx_byte;
               running_xor_in = req_rx_byte;
            end
            POS_LEN: begin
               declared_length_in = req_rx_byte;
               running_xor_in     = running_xor_ff ^ req_rx_byte;
            end
            POS_PAYLOAD: begin
               running_xor_in = running_xor_ff ^ req_rx_byte;
            end
            POS_CHECK: begin
               received_check_in = req_rx_byte;
            end
            default: begin
            end
         endcase
      end

      if (cmd.rsp_load_data) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff    <= START_MARKER_RESET;
         end_marker_ff      <= END_MARKER_RESET;
         byte_count_ff      <= '0;
         declared_length_ff <= '0;
         running_xor_ff     <= '0;
         frame_type_ff      <= '0;
         received_check_ff  <= '0;
         rd_ptr_ff          <= '0;
      end else begin
         start_marker_ff    <= start_marker_in;
         end_marker_ff      <= end_marker_in;
         byte_count_ff      <= byte_count_in;
         declared_length_ff <= declared_length_in;
         running_xor_ff     <= running_xor_in;
         frame_type_ff      <= frame_type_in;
         received_check_ff  <= received_check_in;
         rd_ptr_ff          <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         payload_store_mem[wr_addr] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= payload_store_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.rsp_load_err) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.err_status;
         rsp_type_in   = frame_type_ff;
         rsp_has_in    = 1'b0;
         rsp_data_in   = 8'd0;
         rsp_idx_in    = 5'd0;
         rsp_last_in   = 1'b1;
      end else if (cmd.rsp_load_data) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_OK;
         rsp_type_in   = frame_type_ff;
         rsp_has_in    = 1'b1;
         rsp_data_in   = rd_data_ff;
         rsp_idx_in    = ptr_ext[4:0];
         rsp_last_in   = sts.ptr_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_packet_type  = rsp_type_ff;
   assign rsp_has_data     = rsp_has_ff;
   assign rsp_payload_byte = rsp_data_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
